// ===== rtl/ftmc_pkg.sv =====
// ----------------------------------------------------------------------------
// ftmc_pkg
// Shared types and constants of the focus timer mode controller: mode
// encoding, event codes, register indexes and the config/result bundles.
// ----------------------------------------------------------------------------
package ftmc_pkg;

  // Operating modes, one-hot
  typedef enum logic [4:0] {
    MODE_MENU   = 5'b00001,
    MODE_SELECT = 5'b00010,
    MODE_UP     = 5'b00100,
    MODE_DOWN   = 5'b01000,
    MODE_IDLE   = 5'b10000
  } mode_t;

  // Mode codes as seen on the result port
  localparam logic [2:0] MODE_CODE_MENU   = 3'd0;
  localparam logic [2:0] MODE_CODE_SELECT = 3'd1;
  localparam logic [2:0] MODE_CODE_UP     = 3'd2;
  localparam logic [2:0] MODE_CODE_DOWN   = 3'd3;
  localparam logic [2:0] MODE_CODE_IDLE   = 3'd4;

  // Event codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_BUTTON = 2'd1;
  localparam logic [1:0] OP_ROTATE = 2'd2;

  // Menu entries
  localparam logic [1:0] CHOICE_UP   = 2'd0;
  localparam logic [1:0] CHOICE_DOWN = 2'd1;

  // Register indexes
  localparam logic [1:0] CFG_INACT_IDX   = 2'd0;
  localparam logic [1:0] CFG_BLANK_IDX   = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_IDX = 2'd2;
  localparam logic [1:0] CFG_MAX_IDX     = 2'd3;

  // Register reset values
  localparam logic [31:0] INACT_RESET   = 32'd30000;
  localparam logic [31:0] BLANK_RESET   = 32'd60000;
  localparam logic [9:0]  DEFAULT_RESET = 10'd20;
  localparam logic [9:0]  MAX_RESET     = 10'd999;

  // Timing constants
  localparam logic [15:0] MS_PER_MIN = 16'd60000;
  localparam logic [15:0] MS_PER_SEC = 16'd1000;

  typedef struct packed {
    logic [31:0] inact_limit;
    logic [31:0] blank_limit;
    logic [9:0]  default_min;
    logic [9:0]  max_min;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  menu_choice;
    logic        display_lit;
    logic [15:0] shown_minutes;
    logic [15:0] seconds_left;
    logic [15:0] total_minutes;
    logic        success_pulse;
  } result_t;

  // Map one-hot mode to its port code
  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    unique case (m)
      MODE_MENU:   c = MODE_CODE_MENU;
      MODE_SELECT: c = MODE_CODE_SELECT;
      MODE_UP:     c = MODE_CODE_UP;
      MODE_DOWN:   c = MODE_CODE_DOWN;
      MODE_IDLE:   c = MODE_CODE_IDLE;
      default:     c = MODE_CODE_MENU;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/ftmc_cfg.sv =====
// ----------------------------------------------------------------------------
// ftmc_cfg
// Configuration register file: four write-only registers loaded by index.
// ----------------------------------------------------------------------------
module ftmc_cfg import ftmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  // Load the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inact_limit <= INACT_RESET;
      cfg_r.blank_limit <= BLANK_RESET;
      cfg_r.default_min <= DEFAULT_RESET;
      cfg_r.max_min     <= MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INACT_IDX:   cfg_r.inact_limit <= cfg_wdata;
        CFG_BLANK_IDX:   cfg_r.blank_limit <= cfg_wdata;
        CFG_DEFAULT_IDX: cfg_r.default_min <= cfg_wdata[9:0];
        CFG_MAX_IDX:     cfg_r.max_min     <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/ftmc_core.sv =====
// ----------------------------------------------------------------------------
// ftmc_core
// Mode state and next-state logic: applies one event per enabled cycle and
// presents the state after that event as a result bundle.
// ----------------------------------------------------------------------------
module ftmc_core import ftmc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [1:0]        op,
  input  logic signed [7:0] delta,
  input  cfg_t              cfg,
  output result_t           res
);

  mode_t              mode_r, mode_nxt;
  logic [1:0]         menu_sel_r, menu_sel_nxt;
  logic               blanked_r, blanked_nxt;
  logic signed [7:0]  rot_accum_r, rot_accum_nxt;
  logic [9:0]         sel_min_r, sel_min_nxt;
  logic [9:0]         start_min_r, start_min_nxt;
  logic [15:0]        secs_r, secs_nxt;
  logic [15:0]        up_min_r, up_min_nxt;
  logic [15:0]        period_r, period_nxt;
  logic [31:0]        since_act_r, since_act_nxt;
  logic [31:0]        since_idle_r, since_idle_nxt;
  logic [15:0]        total_r, total_nxt;
  logic               pulse;

  logic [31:0]        since_act_inc, since_idle_inc;
  logic [15:0]        period_inc, up_inc, secs_dec;
  logic [15:0]        secs_bias;
  logic [29:0]        div_prod;
  logic [16:0]        total_plus_start, total_plus_up;
  logic [15:0]        total_sat_start, total_sat_up;
  logic signed [8:0]  acc_sum, step;
  logic signed [9:0]  wrap_s;
  logic [7:0]         wrap_u, wrap_rem;
  logic [15:0]        wrap_prod;
  logic [6:0]         wrap_q;
  logic signed [11:0] sel_sum;
  logic [9:0]         sel_stepped, sel_preset;

  // Limit minutes to 1..max
  function automatic logic [9:0] clamp_min(input logic signed [11:0] v,
                                           input logic [9:0] mx);
    logic signed [11:0] c;
    c = (v > $signed({2'b00, mx})) ? $signed({2'b00, mx}) : v;
    return (c < 12'sd1) ? 10'd1 : c[9:0];
  endfunction

  // Minutes to seconds: x*64 - x*4
  function automatic logic [15:0] times60(input logic [9:0] x);
    return {x, 6'b0} - 16'({x, 2'b0});
  endfunction

  // Saturating counters and a plain period increment
  assign since_act_inc  = (since_act_r == '1) ? since_act_r : since_act_r + 32'd1;
  assign since_idle_inc = (since_idle_r == '1) ? since_idle_r : since_idle_r + 32'd1;
  assign up_inc         = (up_min_r == '1) ? up_min_r : up_min_r + 16'd1;
  assign period_inc     = period_r + 16'd1;
  assign secs_dec       = (secs_r != 16'd0) ? secs_r - 16'd1 : secs_r;

  // Remaining minutes rounded up: ((s + 59) / 4) / 15 via reciprocal 34953 / 2^19
  assign secs_bias = secs_dec + 16'd59;
  assign div_prod  = secs_bias[15:2] * 16'd34953;

  // Saturating total adds
  assign total_plus_start = {1'b0, total_r} + {7'b0, start_min_r};
  assign total_plus_up    = {1'b0, total_r} + {1'b0, up_min_r};
  assign total_sat_start  = total_plus_start[16] ? 16'hFFFF : total_plus_start[15:0];
  assign total_sat_up     = total_plus_up[16] ? 16'hFFFF : total_plus_up[15:0];

  // Encoder: accumulate, step is sum / 4 truncated toward zero
  assign acc_sum = 9'(rot_accum_r) + 9'(delta);
  assign step    = (acc_sum + (acc_sum[8] ? 9'sd3 : 9'sd0)) >>> 2;

  // Menu wrap: offset by a multiple of 3, then remainder via 171 / 2^9
  assign wrap_s    = $signed({8'b0, menu_sel_r}) + 10'(step) + 10'sd66;
  assign wrap_u    = wrap_s[7:0];
  assign wrap_prod = wrap_u * 8'd171;
  assign wrap_q    = wrap_prod[15:9];
  assign wrap_rem  = wrap_u - ({1'b0, wrap_q} + {wrap_q, 1'b0});

  // Selection stepping and preset
  assign sel_sum     = $signed({2'b00, sel_min_r}) + 12'(step);
  assign sel_stepped = clamp_min(sel_sum, cfg.max_min);
  assign sel_preset  = clamp_min($signed({2'b00, cfg.default_min}), cfg.max_min);

  // Next state for one event
  always_comb begin
    mode_nxt       = mode_r;
    menu_sel_nxt   = menu_sel_r;
    blanked_nxt    = blanked_r;
    rot_accum_nxt  = rot_accum_r;
    sel_min_nxt    = sel_min_r;
    start_min_nxt  = start_min_r;
    secs_nxt       = secs_r;
    up_min_nxt     = up_min_r;
    period_nxt     = period_r;
    since_act_nxt  = since_act_r;
    since_idle_nxt = since_idle_r;
    total_nxt      = total_r;
    pulse          = 1'b0;
    case (op)
      OP_TICK: begin
        since_act_nxt = since_act_inc;
        if (mode_r == MODE_IDLE) since_idle_nxt = since_idle_inc;
        // Drop to idle after inactivity
        if ((mode_r == MODE_MENU || mode_r == MODE_SELECT) &&
            since_act_inc > cfg.inact_limit) begin
          mode_nxt       = MODE_IDLE;
          since_idle_nxt = 32'd0;
        end
        if (mode_nxt == MODE_IDLE && !blanked_r && since_idle_nxt > cfg.blank_limit)
          blanked_nxt = 1'b1;
        // Advance session timers
        if (mode_r == MODE_UP) begin
          if (period_inc >= MS_PER_MIN) begin
            period_nxt = 16'd0;
            up_min_nxt = up_inc;
          end else begin
            period_nxt = period_inc;
          end
        end else if (mode_r == MODE_DOWN) begin
          if (period_inc >= MS_PER_SEC) begin
            period_nxt  = 16'd0;
            secs_nxt    = secs_dec;
            sel_min_nxt = div_prod[28:19];
            if (secs_dec == 16'd0) begin
              total_nxt     = total_sat_start;
              pulse         = 1'b1;
              since_act_nxt = 32'd0;
              mode_nxt      = MODE_MENU;
              menu_sel_nxt  = CHOICE_DOWN;
            end
          end else begin
            period_nxt = period_inc;
          end
        end
      end
      OP_BUTTON: begin
        unique case (mode_r)
          MODE_MENU: begin
            since_act_nxt = 32'd0;
            case (menu_sel_r)
              CHOICE_UP: begin
                mode_nxt   = MODE_UP;
                up_min_nxt = 16'd0;
                period_nxt = 16'd0;
              end
              CHOICE_DOWN: begin
                mode_nxt    = MODE_SELECT;
                sel_min_nxt = sel_preset;
                secs_nxt    = times60(sel_preset);
              end
              default: total_nxt = 16'd0;
            endcase
          end
          MODE_SELECT: begin
            since_act_nxt = 32'd0;
            start_min_nxt = sel_min_r;
            secs_nxt      = times60(sel_min_r);
            period_nxt    = 16'd0;
            mode_nxt      = MODE_DOWN;
          end
          MODE_UP: begin
            since_act_nxt = 32'd0;
            total_nxt     = total_sat_up;
            pulse         = 1'b1;
            mode_nxt      = MODE_MENU;
            menu_sel_nxt  = CHOICE_UP;
          end
          MODE_DOWN: begin
            since_act_nxt = 32'd0;
            mode_nxt      = MODE_MENU;
            menu_sel_nxt  = CHOICE_DOWN;
          end
          MODE_IDLE: begin
            mode_nxt      = MODE_MENU;
            blanked_nxt   = 1'b0;
            since_act_nxt = 32'd0;
          end
          default: ;
        endcase
      end
      OP_ROTATE: begin
        if (step == 9'sd0) begin
          rot_accum_nxt = acc_sum[7:0];
        end else begin
          rot_accum_nxt = 8'sd0;
          since_act_nxt = 32'd0;
          if (mode_r == MODE_IDLE) begin
            mode_nxt    = MODE_MENU;
            blanked_nxt = 1'b0;
          end else if (mode_r == MODE_MENU) begin
            menu_sel_nxt = wrap_rem[1:0];
          end else if (mode_r == MODE_SELECT) begin
            sel_min_nxt = sel_stepped;
          end
        end
      end
      default: ;
    endcase
  end

  // Present the state after the event
  always_comb begin
    res.mode          = mode_code(mode_nxt);
    res.menu_choice   = menu_sel_nxt;
    res.display_lit   = !blanked_nxt;
    res.shown_minutes = (mode_nxt == MODE_UP) ? up_min_nxt : {6'b0, sel_min_nxt};
    res.seconds_left  = (mode_nxt == MODE_DOWN) ? secs_nxt : 16'd0;
    res.total_minutes = total_nxt;
    res.success_pulse = pulse;
  end

  // Commit state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_MENU;
      menu_sel_r   <= CHOICE_UP;
      blanked_r    <= 1'b0;
      rot_accum_r  <= 8'sd0;
      sel_min_r    <= 10'd0;
      start_min_r  <= 10'd0;
      secs_r       <= 16'd0;
      up_min_r     <= 16'd0;
      period_r     <= 16'd0;
      since_act_r  <= 32'd0;
      since_idle_r <= 32'd0;
      total_r      <= 16'd0;
    end else if (step_en) begin
      mode_r       <= mode_nxt;
      menu_sel_r   <= menu_sel_nxt;
      blanked_r    <= blanked_nxt;
      rot_accum_r  <= rot_accum_nxt;
      sel_min_r    <= sel_min_nxt;
      start_min_r  <= start_min_nxt;
      secs_r       <= secs_nxt;
      up_min_r     <= up_min_nxt;
      period_r     <= period_nxt;
      since_act_r  <= since_act_nxt;
      since_idle_r <= since_idle_nxt;
      total_r      <= total_nxt;
    end
  end

  // Blanking only happens while idle
  a_blank_idle: assert property (@(posedge clk) disable iff (!rst_n)
    blanked_r |-> mode_r == MODE_IDLE)
    else $error("display blanked outside idle");

  // Leftover encoder counts never reach a full step
  a_accum_range: assert property (@(posedge clk) disable iff (!rst_n)
    rot_accum_r >= -8'sd3 && rot_accum_r <= 8'sd3)
    else $error("encoder accumulator out of range");

  // A completed session always returns to the menu
  a_pulse_menu: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && pulse |=> mode_r == MODE_MENU)
    else $error("success pulse without return to menu");

endmodule

// ===== rtl/focus_timer_mode_controller_top.sv =====
// ----------------------------------------------------------------------------
// focus_timer_mode_controller_top
// Focus timer mode controller: input register, single-pass event update and
// result register, plus the configuration registers.
// ----------------------------------------------------------------------------
//   Channel  Handshake           Payload
//   in_      in_valid/in_ready   in_operation, in_rotation_delta
//   out_     out_valid/out_ready mode, menu choice, display, minutes, seconds,
//                                total, success pulse
//   cfg_     cfg_we              cfg_index, cfg_wdata
//
// One request per cycle sustained while out_ready is high; a request is captured in the
// input register and its result in the result register, where it waits for out_ready.
// The event update is one combinational pass between the two registers.
// A stalled result register holds and backs up the input register; both
// sides keep moving when out_ready is high.
// Synchronous active-low reset restores the menu mode and register defaults.
// ----------------------------------------------------------------------------
module focus_timer_mode_controller_top import ftmc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic signed [7:0] in_rotation_delta,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_mode,
  output logic [1:0]        out_menu_choice,
  output logic              out_display_lit,
  output logic [15:0]       out_shown_minutes,
  output logic [15:0]       out_seconds_left,
  output logic [15:0]       out_total_minutes,
  output logic              out_success_pulse,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);

  logic              in_valid_r;
  logic [1:0]        op_r;
  logic signed [7:0] delta_r;
  logic              out_valid_r;
  result_t           out_r;
  result_t           res;
  cfg_t              cfg;
  logic              adv;

  ftmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ftmc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .op      (op_r),
    .delta   (delta_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Advance when a request is held and the result slot is free or draining
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= in_operation;
      delta_r <= in_rotation_delta;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mode          = out_r.mode;
  assign out_menu_choice   = out_r.menu_choice;
  assign out_display_lit   = out_r.display_lit;
  assign out_shown_minutes = out_r.shown_minutes;
  assign out_seconds_left  = out_r.seconds_left;
  assign out_total_minutes = out_r.total_minutes;
  assign out_success_pulse = out_r.success_pulse;

  // Every processed request lands in the result register
  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("processed request lost before result register");

endmodule

// ===== tb/focus_timer_mode_controller_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// focus_timer_mode_controller_top_test
// Self-checking bench for the focus timer mode controller. A cycle-free
// timer model predicts the display after every event; each returned result
// is compared field by field. Directed tests cover encoder stepping, menu
// wrap, selection clamp, idle and blanking, register extremes and short count
// up and countdown sessions, followed by output backpressure and random
// event traffic under several register settings.
// ----------------------------------------------------------------------------
module focus_timer_mode_controller_top_test;
  import ftmc_pkg::*;

  localparam logic [1:0] CHOICE_TOTAL     = 2'd2;
  localparam logic [1:0] OP_IGNORED       = 2'd3;
  localparam int         SECS_PER_MIN     = 60;
  localparam int         SETTLE_CYCLES    = 4;
  localparam int         LONG_HOLD_CYCLES = 400;
  localparam int         WATCHDOG_LIMIT   = 3000;
  localparam int         RANDOM_PER_PHASE = 180;

  // DUT ports
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_operation = OP_TICK;
  logic signed [7:0] in_rotation_delta = 8'sd0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        out_mode;
  logic [1:0]        out_menu_choice;
  logic              out_display_lit;
  logic [15:0]       out_shown_minutes;
  logic [15:0]       out_seconds_left;
  logic [15:0]       out_total_minutes;
  logic              out_success_pulse;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = CFG_INACT_IDX;
  logic [31:0]       cfg_wdata = 32'd0;

  // Timer settings as last written
  logic [31:0] lim_inact  = INACT_RESET;
  logic [31:0] lim_blank  = BLANK_RESET;
  logic [9:0]  preset_min = DEFAULT_RESET;
  logic [9:0]  cap_min    = MAX_RESET;

  // Timer state as predicted
  logic [2:0]        mode_q       = MODE_CODE_MENU;
  logic [1:0]        choice_q     = CHOICE_UP;
  logic              blank_q      = 1'b0;
  logic signed [7:0] accum_q      = 8'sd0;
  logic [9:0]        sel_q        = 10'd0;
  logic [9:0]        start_q      = 10'd0;
  logic [15:0]       secs_q       = 16'd0;
  logic [15:0]       up_q         = 16'd0;
  logic [15:0]       period_q     = 16'd0;
  logic [31:0]       since_act_q  = 32'd0;
  logic [31:0]       since_idle_q = 32'd0;
  logic [15:0]       total_q      = 16'd0;

  result_t pending_displays[$];
  int      requests_sent = 0;
  int      results_seen  = 0;
  int      sessions_done = 0;
  int      mismatches    = 0;
  int      quiet_cycles  = 0;
  bit      sender_gaps   = 1'b1;
  bit      sink_stalls   = 1'b1;
  bit      hold_results  = 1'b0;

  focus_timer_mode_controller_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_rotation_delta (in_rotation_delta),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mode          (out_mode),
    .out_menu_choice   (out_menu_choice),
    .out_display_lit   (out_display_lit),
    .out_shown_minutes (out_shown_minutes),
    .out_seconds_left  (out_seconds_left),
    .out_total_minutes (out_total_minutes),
    .out_success_pulse (out_success_pulse),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Timer prediction
  // ------------------------------------------------------------------

  function automatic logic [9:0] clamp_minutes(input int v);
    if (v > int'(cap_min)) v = int'(cap_min);
    if (v < 1) v = 1;
    return v[9:0];
  endfunction

  // Saturate the focus total at its 16-bit ceiling
  function automatic void add_focus(input logic [15:0] m);
    int sum;
    sum = int'(total_q) + int'(m);
    total_q = (sum > 32'hFFFF) ? 16'hFFFF : sum[15:0];
  endfunction

  function automatic void wake_display();
    mode_q = MODE_CODE_MENU;
    blank_q = 1'b0;
    since_act_q = '0;
  endfunction

  // Apply one event to the timer state and return the display after it
  function automatic result_t timer_next_result(input logic [1:0] op,
                                                input logic signed [7:0] delta);
    result_t r;
    logic    pulse;
    int      sum;
    int      step;
    int      m;
    int      minutes;
    pulse = 1'b0;
    case (op)
      OP_TICK: begin
        if (since_act_q != '1) since_act_q++;
        if (mode_q == MODE_CODE_IDLE && since_idle_q != '1) since_idle_q++;
        // Fall idle after too long without activity
        if ((mode_q == MODE_CODE_MENU || mode_q == MODE_CODE_SELECT) &&
            since_act_q > lim_inact) begin
          mode_q = MODE_CODE_IDLE;
          since_idle_q = '0;
        end
        if (mode_q == MODE_CODE_IDLE && !blank_q && since_idle_q > lim_blank)
          blank_q = 1'b1;
        if (mode_q == MODE_CODE_UP) begin
          period_q++;
          if (period_q >= MS_PER_MIN) begin
            period_q = '0;
            if (up_q != '1) up_q++;
          end
        end else if (mode_q == MODE_CODE_DOWN) begin
          period_q++;
          if (period_q >= MS_PER_SEC) begin
            period_q = '0;
            if (secs_q != 0) secs_q--;
            minutes = (int'(secs_q) + SECS_PER_MIN - 1) / SECS_PER_MIN;
            sel_q = minutes[9:0];
            // Countdown finished: credit the session
            if (secs_q == 0) begin
              add_focus({6'd0, start_q});
              pulse = 1'b1;
              since_act_q = '0;
              mode_q = MODE_CODE_MENU;
              choice_q = CHOICE_DOWN;
            end
          end
        end
      end
      OP_BUTTON: begin
        case (mode_q)
          MODE_CODE_MENU: begin
            since_act_q = '0;
            if (choice_q == CHOICE_UP) begin
              mode_q = MODE_CODE_UP;
              up_q = '0;
              period_q = '0;
            end else if (choice_q == CHOICE_DOWN) begin
              mode_q = MODE_CODE_SELECT;
              sel_q = clamp_minutes(int'(preset_min));
              secs_q = 16'(int'(sel_q) * SECS_PER_MIN);
            end else begin
              total_q = '0;
            end
          end
          MODE_CODE_SELECT: begin
            since_act_q = '0;
            start_q = sel_q;
            secs_q = 16'(int'(sel_q) * SECS_PER_MIN);
            period_q = '0;
            mode_q = MODE_CODE_DOWN;
          end
          MODE_CODE_UP: begin
            since_act_q = '0;
            add_focus(up_q);
            pulse = 1'b1;
            mode_q = MODE_CODE_MENU;
            choice_q = CHOICE_UP;
          end
          MODE_CODE_DOWN: begin
            since_act_q = '0;
            mode_q = MODE_CODE_MENU;
            choice_q = CHOICE_DOWN;
          end
          default: wake_display();
        endcase
      end
      OP_ROTATE: begin
        sum = int'(accum_q) + int'(delta);
        step = sum / 4;
        if (step == 0) begin
          accum_q = sum[7:0];
        end else begin
          accum_q = '0;
          if (mode_q == MODE_CODE_IDLE) begin
            wake_display();
          end else begin
            since_act_q = '0;
            // Wrap the menu with a positive modulo
            if (mode_q == MODE_CODE_MENU) begin
              m = (int'(choice_q) + step) % 3;
              if (m < 0) m += 3;
              choice_q = m[1:0];
            end else if (mode_q == MODE_CODE_SELECT) begin
              sel_q = clamp_minutes(int'(sel_q) + step);
            end
          end
        end
      end
      default: ;
    endcase
    r.mode          = mode_q;
    r.menu_choice   = choice_q;
    r.display_lit   = !blank_q;
    r.shown_minutes = (mode_q == MODE_CODE_UP) ? up_q : {6'd0, sel_q};
    r.seconds_left  = (mode_q == MODE_CODE_DOWN) ? secs_q : 16'd0;
    r.total_minutes = total_q;
    r.success_pulse = pulse;
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------

  // Offer one event, hold it until taken, then record its display
  task automatic send_event(input logic [1:0] op, input logic signed [7:0] delta);
    int gap;
    if (sender_gaps && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_operation      <= op;
    in_rotation_delta <= delta;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_displays.push_back(timer_next_result(op, delta));
    requests_sent++;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_event(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Drop valid and wait for every pending display to come back
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_INACT_IDX:   lim_inact  = value;
      CFG_BLANK_IDX:   lim_blank  = value;
      CFG_DEFAULT_IDX: preset_min = value[9:0];
      CFG_MAX_IDX:     cap_min    = value[9:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [31:0] inact, input logic [31:0] blank,
                               input logic [9:0] dflt, input logic [9:0] cap);
    settle_pipeline();
    write_register(CFG_INACT_IDX, inact);
    write_register(CFG_BLANK_IDX, blank);
    write_register(CFG_DEFAULT_IDX, {22'd0, dflt});
    write_register(CFG_MAX_IDX, {22'd0, cap});
  endtask

  // Press the button until the predicted mode is the menu
  task automatic return_to_menu();
    while (mode_q != MODE_CODE_MENU) send_event(OP_BUTTON, 8'sd0);
  endtask

  task automatic pick_choice(input logic [1:0] target);
    return_to_menu();
    while (choice_q != target) send_event(OP_ROTATE, 8'sd4);
  endtask

  task automatic send_random_event();
    int                pick;
    int                span;
    logic signed [7:0] d;
    pick = $urandom_range(0, 399);
    d = 8'($urandom_range(0, 255));
    if (pick == 0) begin
      // Long tick run so idle, blank and session timers advance
      span = $urandom_range(50, 300);
      send_ticks(span);
    end else if (pick < 160) begin
      send_event(OP_TICK, d);
    end else if (pick < 232) begin
      send_event(OP_BUTTON, d);
    end else if (pick < 340) begin
      send_event(OP_ROTATE, 8'(int'($urandom_range(0, 16)) - 8));
    end else if (pick < 385) begin
      send_event(OP_ROTATE, d);
    end else begin
      send_event(OP_IGNORED, d);
    end
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Encoder accumulation, menu wrap both ways, total reset, unused code
  task automatic test_menu_and_encoder();
    send_event(OP_BUTTON, 8'sd0);
    send_event(OP_TICK, 8'sd0);
    send_event(OP_BUTTON, 8'sd0);
    send_event(OP_ROTATE, 8'sd3);
    send_event(OP_ROTATE, 8'sd1);
    send_event(OP_ROTATE, -8'sd128);
    send_event(OP_ROTATE, 8'sd127);
    send_event(OP_ROTATE, -8'sd5);
    send_event(OP_BUTTON, 8'sd0);
    send_event(OP_IGNORED, -8'sd1);
    send_event(OP_ROTATE, -8'sd2);
    send_event(OP_ROTATE, -8'sd1);
    send_event(OP_ROTATE, -8'sd1);
  endtask

  // Preset above the cap, clamp at both ends, short countdown then abort
  task automatic test_selection_clamp();
    load_settings(INACT_RESET, BLANK_RESET, 10'd30, 10'd25);
    pick_choice(CHOICE_DOWN);
    send_event(OP_BUTTON, 8'sd0);
    send_event(OP_ROTATE, 8'sd127);
    send_event(OP_ROTATE, -8'sd128);
    send_event(OP_ROTATE, 8'sd8);
    send_event(OP_BUTTON, 8'sd0);
    send_ticks(3);
    send_event(OP_BUTTON, 8'sd0);
  endtask

  // Zero limits: idle and blank on consecutive ticks, wake by button and encoder
  task automatic test_idle_and_blank();
    load_settings(32'd0, 32'd0, DEFAULT_RESET, MAX_RESET);
    send_ticks(2);
    send_event(OP_BUTTON, 8'sd0);
    send_ticks(2);
    send_event(OP_ROTATE, 8'sd2);
    send_event(OP_ROTATE, 8'sd2);
  endtask

  // Largest limits, preset at its top with the smallest and largest cap
  task automatic test_register_extremes();
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd999, 10'd1);
    pick_choice(CHOICE_DOWN);
    send_event(OP_BUTTON, 8'sd0);
    send_event(OP_ROTATE, 8'sd127);
    send_ticks(4);
    return_to_menu();
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1, 10'd999);
    write_register(CFG_DEFAULT_IDX, 32'd999);
    pick_choice(CHOICE_DOWN);
    send_event(OP_BUTTON, 8'sd0);
    send_event(OP_ROTATE, 8'sd127);
    send_event(OP_ROTATE, -8'sd128);
    return_to_menu();
  endtask

  // Short count up ended by the button, then a countdown past its first second
  task automatic test_full_sessions();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    load_settings(32'hFFFF_FFFF, BLANK_RESET, 10'd1, MAX_RESET);
    pick_choice(CHOICE_UP);
    send_event(OP_BUTTON, 8'sd0);
    send_ticks(5);
    send_event(OP_BUTTON, 8'sd0);
    pick_choice(CHOICE_DOWN);
    send_event(OP_BUTTON, 8'sd0);
    send_event(OP_BUTTON, 8'sd0);
    send_ticks(1001);
    send_event(OP_BUTTON, 8'sd0);
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // Stall the result side long enough to back the pipeline up
  task automatic test_backpressure();
    settle_pipeline();
    hold_results = 1'b1;
    repeat (40) send_random_event();
  endtask

  task automatic test_random_traffic();
    int phase_start;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: load_settings($urandom_range(0, 40), $urandom_range(0, 30),
                         10'($urandom_range(1, 999)), 10'($urandom_range(1, 999)));
        1: load_settings(32'd0, 32'd0, 10'd1, 10'd999);
        2: load_settings($urandom_range(100, 3000), $urandom_range(0, 2000),
                         10'd999, 10'd1);
        default: load_settings($urandom_range(20, 200), $urandom_range(5, 100),
                               10'($urandom_range(1, 60)),
                               10'($urandom_range(1, 999)));
      endcase
      // No idling on either side in the closing phase
      sender_gaps = (phase != 3);
      sink_stalls = (phase != 3);
      phase_start = requests_sent;
      while (requests_sent - phase_start < RANDOM_PER_PHASE) send_random_event();
    end
  endtask

  // ------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------

  // Accept results, with random stalls and one long hold when asked
  initial begin : result_sink
    int pause;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
        pause = $urandom_range(1, 15);
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", what, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result with the oldest predicted display
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_success_pulse === 1'b1) sessions_done++;
      if (pending_displays.size() == 0) begin
        $error("result with no pending request: mode %0d", out_mode);
        mismatches++;
      end else begin
        want = pending_displays.pop_front();
        check_field("mode", 32'(want.mode), 32'(out_mode));
        check_field("menu_choice", 32'(want.menu_choice), 32'(out_menu_choice));
        check_field("display_lit", 32'(want.display_lit), 32'(out_display_lit));
        check_field("shown_minutes", 32'(want.shown_minutes), 32'(out_shown_minutes));
        check_field("seconds_left", 32'(want.seconds_left), 32'(out_seconds_left));
        check_field("total_minutes", 32'(want.total_minutes), 32'(out_total_minutes));
        check_field("success_pulse", 32'(want.success_pulse), 32'(out_success_pulse));
      end
    end
  end

  // End the run if no request or result moves for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no traffic for %0d cycles", quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------

  initial begin : test_sequence
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_menu_and_encoder();
    test_selection_clamp();
    test_idle_and_blank();
    test_register_extremes();
    test_full_sessions();
    test_backpressure();
    test_random_traffic();
    settle_pipeline();
    $display("Run covered %0d requests and %0d results, %0d completed sessions,",
             requests_sent, results_seen, sessions_done);
    $display("across directed, session, backpressure and four random phases.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
